/* design/zobrist_position_hash_macros.svh */
// ---------------------------------------------------------------------------
// Zobrist position hash assertion macros
// Concurrent assertion wrappers used by the top-level design file.
// ---------------------------------------------------------------------------
`ifndef ZOBRIST_POSITION_HASH_MACROS_SVH
`define ZOBRIST_POSITION_HASH_MACROS_SVH

`ifndef SYNTHESIS
`define ZPH_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zph assertion failed");
`define ZPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zph assertion failed");
`else
`define ZPH_ASSERT(label, clk, rst, ante, cons)
`define ZPH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* design/zph_pkg.sv */
// ---------------------------------------------------------------------------
// Zobrist position hash package
// Constants, key generator function and interface structs.
// ---------------------------------------------------------------------------
package zph_pkg;

  localparam logic [63:0] ZPH_SEED = 64'd12436596276006385841;

  localparam int ZPH_SQUARES       = 64;
  localparam int ZPH_PIECES        = 12;
  localparam int ZPH_PS_KEYS       = 768;
  localparam int ZPH_SIDE_INDEX    = 768;
  localparam int ZPH_CASTLE_BASE   = 769;
  localparam int ZPH_PASSANT_BASE  = 785;
  localparam int ZPH_TOTAL_KEYS    = 849;
  localparam int ZPH_AUX_KEYS      = 80;
  localparam int ZPH_AUX_CASTLE_OFS = 64;
  localparam int ZPH_OUT_DEPTH     = 4;
  localparam int ZPH_IN_W          = 24;
  localparam int ZPH_HASH_W        = 64;

  typedef logic [ZPH_HASH_W-1:0] zph_key_t;
  typedef logic [9:0]            zph_ps_addr_t;
  typedef logic [6:0]            zph_aux_addr_t;

  typedef struct packed {
    logic          ps_we;
    logic          side_we;
    logic          aux_we;
    zph_ps_addr_t  ps_addr;
    zph_aux_addr_t aux_addr;
    zph_key_t      key;
  } zph_key_wr_t;

  typedef struct packed {
    zph_ps_addr_t  ps_addr;
    zph_aux_addr_t castle_addr;
    zph_aux_addr_t passant_addr;
  } zph_key_rd_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic pc_ok;
    logic black;
    logic ep_ok;
  } zph_beat_t;

  function automatic zph_key_t zph_xorshift(input zph_key_t x);
    zph_key_t a;
    zph_key_t b;
    zph_key_t c;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    c = b ^ (b << 5);
    return c;
  endfunction

endpackage

/* design/zph_keygen.sv */
// ---------------------------------------------------------------------------
// Zobrist key generator
// Runs the xorshift generator after reset and writes one key per cycle.
// ---------------------------------------------------------------------------
module zph_keygen (
  input  logic               clk,
  input  logic               rst,
  output zph_pkg::zph_key_wr_t wr,
  output logic               done
);
  import zph_pkg::*;

  zph_key_t     gen_state;
  zph_key_t     key_next;
  logic [9:0]   fill_counter;

  assign key_next = zph_xorshift(gen_state);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state    <= ZPH_SEED;
      fill_counter <= '0;
      done         <= 1'b0;
    end else if (!done) begin
      gen_state    <= key_next;
      fill_counter <= fill_counter + 10'd1;
      if (fill_counter == 10'(ZPH_TOTAL_KEYS - 1)) begin
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    wr.key     = key_next;
    wr.ps_we   = !done && (fill_counter < 10'(ZPH_PS_KEYS));
    wr.ps_addr = fill_counter;
    wr.side_we = !done && (fill_counter == 10'(ZPH_SIDE_INDEX));
    wr.aux_we  = !done && (fill_counter >= 10'(ZPH_CASTLE_BASE));
    if (fill_counter < 10'(ZPH_PASSANT_BASE)) begin
      wr.aux_addr = 7'(fill_counter - 10'(ZPH_CASTLE_BASE) + 10'(ZPH_AUX_CASTLE_OFS));
    end else begin
      wr.aux_addr = 7'(fill_counter - 10'(ZPH_PASSANT_BASE));
    end
  end

endmodule

/* design/zph_key_store.sv */
// ---------------------------------------------------------------------------
// Zobrist key store
// Piece-square key memory, castling and en-passant key memory, side key.
// ---------------------------------------------------------------------------
module zph_key_store (
  input  logic                 clk,
  input  zph_pkg::zph_key_wr_t wr,
  input  zph_pkg::zph_key_rd_t rd,
  output zph_pkg::zph_key_t    ps_key,
  output zph_pkg::zph_key_t    castle_key,
  output zph_pkg::zph_key_t    passant_key,
  output zph_pkg::zph_key_t    turn_key
);
  import zph_pkg::*;

  zph_key_t ps_mem  [ZPH_PS_KEYS];
  zph_key_t aux_mem [ZPH_AUX_KEYS];

  always_ff @(posedge clk) begin
    if (wr.ps_we) begin
      ps_mem[wr.ps_addr] <= wr.key;
    end
    ps_key <= ps_mem[rd.ps_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.aux_we) begin
      aux_mem[wr.aux_addr] <= wr.key;
    end
    castle_key  <= aux_mem[rd.castle_addr];
    passant_key <= aux_mem[rd.passant_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.side_we) begin
      turn_key <= wr.key;
    end
  end

endmodule

/* design/zph_accum.sv */
// ---------------------------------------------------------------------------
// Zobrist hash accumulator
// Folds the looked-up keys into the running hash and forms the result.
// ---------------------------------------------------------------------------
module zph_accum (
  input  logic               clk,
  input  logic               rst,
  input  zph_pkg::zph_beat_t beat,
  input  zph_pkg::zph_key_t  ps_key,
  input  zph_pkg::zph_key_t  castle_key,
  input  zph_pkg::zph_key_t  passant_key,
  input  zph_pkg::zph_key_t  turn_key,
  output logic               push,
  output zph_pkg::zph_key_t  push_hash
);
  import zph_pkg::*;

  zph_beat_t stage;
  zph_key_t  running_hash;
  zph_key_t  running_hash_next;
  zph_key_t  acc;

  always_comb begin
    acc       = running_hash ^ (stage.pc_ok ? ps_key : '0);
    push_hash = acc ^ (stage.black ? turn_key : '0) ^ castle_key
              ^ (stage.ep_ok ? passant_key : '0);
    push      = stage.valid && stage.last;
    if (!stage.valid) begin
      running_hash_next = running_hash;
    end else if (stage.last) begin
      running_hash_next = '0;
    end else begin
      running_hash_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage        <= '0;
      running_hash <= '0;
    end else begin
      stage        <= beat;
      running_hash <= running_hash_next;
    end
  end

endmodule

/* design/zph_out_fifo.sv */
// ---------------------------------------------------------------------------
// Zobrist result queue
// Small queue that holds finished hashes until the sink takes them.
// ---------------------------------------------------------------------------
module zph_out_fifo #(
  parameter int DEPTH = zph_pkg::ZPH_OUT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  zph_pkg::zph_key_t           push_data,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output zph_pkg::zph_key_t           m_tdata,
  output logic [$clog2(DEPTH+1)-1:0]  count
);
  import zph_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  zph_key_t          mem [DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic              pop;

  assign m_tvalid = (count != '0);
  assign m_tdata  = mem[head];
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      end
      if (pop) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* design/zobrist_position_hash.sv */
// ---------------------------------------------------------------------------
// Zobrist position hash
// Chess position hashing with xorshift-generated keys held in memory.
// ---------------------------------------------------------------------------
// After reset the block draws its 849 keys, one per cycle, into its key
// memories, and s_tready stays low until they are all written. From then on
// it takes one beat per cycle while its result queue has room: each beat
// looks up one piece-square key in the same cycle it is accepted, and the
// next cycle folds it into the running hash register, whose feedback sets
// the rate. The result of a beat with tlast is registered in the accumulator
// stage, then written into a queue of OUT_DEPTH entries, where it waits for
// the master side; s_tready drops when that queue and the result in flight
// leave no room.
`include "zobrist_position_hash_macros.svh"

module zobrist_position_hash #(
  parameter int OUT_DEPTH = zph_pkg::ZPH_OUT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // square_index[5:0], piece_code[9:6], black_to_move[10],
  // castling_mask[14:11], passant_square[21:15], zero fill[23:22]
  input  logic [zph_pkg::ZPH_IN_W-1:0] s_tdata,
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // position_hash[63:0]
  output zph_pkg::zph_key_t            m_tdata
);
  import zph_pkg::*;

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic [5:0]        square_index;
  logic [3:0]        piece_code;
  logic              black_to_move;
  logic [3:0]        castling_mask;
  logic [6:0]        passant_square;
  logic              fill_done;
  logic              result_push;
  zph_key_t          result_hash;
  logic [CNT_W-1:0]  fifo_count;
  zph_key_wr_t       key_wr;
  zph_key_rd_t       key_rd;
  zph_beat_t         beat;
  zph_key_t          ps_key;
  zph_key_t          castle_key;
  zph_key_t          passant_key;
  zph_key_t          turn_key;

  assign square_index   = s_tdata[5:0];
  assign piece_code     = s_tdata[9:6];
  assign black_to_move  = s_tdata[10];
  assign castling_mask  = s_tdata[14:11];
  assign passant_square = s_tdata[21:15];

  assign s_tready = fill_done
                 && (({1'b0, fifo_count} + (CNT_W + 1)'(result_push))
                     < (CNT_W + 1)'(OUT_DEPTH));

  always_comb begin
    beat.valid = s_tvalid && s_tready;
    beat.last  = s_tlast;
    beat.pc_ok = (piece_code < 4'(ZPH_PIECES));
    beat.black = black_to_move;
    beat.ep_ok = (passant_square < 7'(ZPH_SQUARES));
    key_rd.ps_addr      = beat.pc_ok ? {piece_code, square_index} : '0;
    key_rd.castle_addr  = 7'(ZPH_AUX_CASTLE_OFS) + {3'b000, castling_mask};
    key_rd.passant_addr = {1'b0, passant_square[5:0]};
  end

  zph_keygen u_keygen (
    .clk  (clk),
    .rst  (rst),
    .wr   (key_wr),
    .done (fill_done)
  );

  zph_key_store u_key_store (
    .clk         (clk),
    .wr          (key_wr),
    .rd          (key_rd),
    .ps_key      (ps_key),
    .castle_key  (castle_key),
    .passant_key (passant_key),
    .turn_key    (turn_key)
  );

  zph_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .beat        (beat),
    .ps_key      (ps_key),
    .castle_key  (castle_key),
    .passant_key (passant_key),
    .turn_key    (turn_key),
    .push        (result_push),
    .push_hash   (result_hash)
  );

  zph_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (result_push),
    .push_data (result_hash),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .count     (fifo_count)
  );

  `ZPH_ASSERT(a_ready_after_fill, clk, rst, s_tready, fill_done)
  `ZPH_ASSERT_NEXT(a_fill_sticks, clk, rst, fill_done, fill_done)
  `ZPH_ASSERT(a_queue_room, clk, rst, result_push, fifo_count < CNT_W'(OUT_DEPTH))
  `ZPH_ASSERT_NEXT(a_last_pushes, clk, rst, s_tvalid && s_tready && s_tlast, result_push)

endmodule

/* sim/tb_zobrist_position_hash.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Zobrist position hash testbench
// Streams chess positions, one piece per beat with tlast on the final beat,
// into the hash block, and compares every emitted hash against a predictor
// that builds its own xorshift key tables. Both stream sides stall at random.
// ---------------------------------------------------------------------------
module tb_zobrist_position_hash;
  import zph_pkg::*;

  class hash_scoreboard;
    logic [63:0] keys[ZPH_TOTAL_KEYS];
    logic [63:0] board_hash;
    logic [63:0] pending_hashes[$];
    int          mismatches;

    function new();
      logic [63:0] x;
      x = ZPH_SEED;
      for (int i = 0; i < ZPH_TOTAL_KEYS; i++) begin
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        keys[i] = x;
      end
      board_hash = '0;
      mismatches = 0;
    endfunction

    function void note_beat(logic [ZPH_IN_W-1:0] d, logic last);
      logic [5:0] sq;
      logic [3:0] pc;
      logic       black;
      logic [3:0] castle;
      logic [6:0] ep;
      logic [63:0] h;
      sq     = d[5:0];
      pc     = d[9:6];
      black  = d[10];
      castle = d[14:11];
      ep     = d[21:15];
      if (pc < ZPH_PIECES)
        board_hash ^= keys[pc * ZPH_SQUARES + sq];
      if (last) begin
        h = board_hash;
        if (black)
          h ^= keys[ZPH_SIDE_INDEX];
        h ^= keys[ZPH_CASTLE_BASE + castle];
        if (ep < ZPH_SQUARES)
          h ^= keys[ZPH_PASSANT_BASE + ep];
        pending_hashes.push_back(h);
        board_hash = '0;
      end
    endfunction

    function void check_hash(logic [63:0] got);
      logic [63:0] want;
      if (pending_hashes.size() == 0) begin
        $error("position_hash: unexpected beat, actual %h", got);
        mismatches++;
      end else begin
        want = pending_hashes.pop_front();
        if (got !== want) begin
          $error("position_hash mismatch: expected %h, actual %h", want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return pending_hashes.size();
    endfunction

    function bit clean();
      if (pending_hashes.size() != 0)
        $error("position_hash: %0d expected beats never arrived", pending_hashes.size());
      return mismatches == 0 && pending_hashes.size() == 0;
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [ZPH_IN_W-1:0] s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  zph_key_t            m_tdata;

  hash_scoreboard sb = new();
  int  items_sent = 0;
  int  hashes_seen = 0;
  bit  calm = 0;
  bit  drained_once = 0;

  zobrist_position_hash DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_beat(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        sb.check_hash(m_tdata);
        hashes_seen++;
      end
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic send_piece(logic [5:0] sq, logic [3:0] pc, logic black,
                            logic [3:0] castle, logic [6:0] ep, logic last);
    if (!calm && $urandom_range(0, 7) == 0)
      idle_cycles($urandom_range(1, 17));
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, ep, castle, black, pc, sq};
    s_tlast  <= last;
    do
      @(posedge clk);
    while (!s_tready);
    items_sent++;
    if (items_sent >= 1500)
      calm = 1;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() > 0)
      @(posedge clk);
  endtask

  task automatic play_position();
    int   len;
    int   r;
    logic [3:0] pc;
    logic [6:0] ep;
    len = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : $urandom_range(1, 20);
    for (int j = 0; j < len; j++) begin
      pc = ($urandom_range(0, 19) < 17) ? 4'($urandom_range(0, 11)) : 4'($urandom_range(12, 15));
      if (j == len - 1) begin
        r = $urandom_range(0, 9);
        ep = (r < 5) ? 7'($urandom_range(0, 63)) :
             (r < 8) ? 7'(ZPH_SQUARES) : 7'($urandom_range(65, 127));
        send_piece(6'($urandom_range(0, 63)), pc, 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)), ep, 1'b1);
      end else begin
        send_piece(6'($urandom_range(0, 63)), pc, 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)), 1'b0);
      end
    end
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!drained_once && hashes_seen >= 40) begin
        drained_once = 1;
        m_tready <= 1'b0;
        repeat (299) @(negedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    bit paused;
    paused   = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed positions: field extremes, empty squares, no en-passant square.
    send_piece(6'd0,  4'd0,  1'b1, 4'd15, 7'd127, 1'b0);
    send_piece(6'd63, 4'd11, 1'b0, 4'd0,  7'd0,   1'b0);
    send_piece(6'd5,  4'd12, 1'b1, 4'd9,  7'd64,  1'b0);
    send_piece(6'd9,  4'd15, 1'b1, 4'd15, 7'd0,   1'b1);
    send_piece(6'd20, 4'd12, 1'b0, 4'd0,  7'd64,  1'b1);
    send_piece(6'd63, 4'd11, 1'b1, 4'd10, 7'd63,  1'b1);
    send_piece(6'd32, 4'd6,  1'b0, 4'd5,  7'd127, 1'b1);
    send_piece(6'd17, 4'd13, 1'b1, 4'd3,  7'd65,  1'b1);
    for (int k = 0; k < ZPH_PIECES; k++)
      send_piece(6'(k * 5 + 3), 4'(k), 1'b1, 4'(k), 7'(k * 5), k == ZPH_PIECES - 1);

    while (items_sent < 1750) begin
      if (!paused && items_sent >= 800) begin
        paused = 1;
        wait_drained();
      end
      play_position();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.clean())
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/zph_pkg.sv
design/zph_keygen.sv
design/zph_key_store.sv
design/zph_accum.sv
design/zph_out_fifo.sv
design/zobrist_position_hash.sv
sim/tb_zobrist_position_hash.sv
